// ===== hw/rtl/abkf_pkg.sv =====
// Package for the angle and gyro bias Kalman filter unit.
// Holds register indexes, reset values, sequencer states, divider request and response types
// and a saturation helper. No dependencies.
package abkf_pkg;

   localparam int unsigned DivSteps = 64;

   localparam logic [2:0] CSR_Q_ANGLE     = 3'd0;
   localparam logic [2:0] CSR_Q_BIAS      = 3'd1;
   localparam logic [2:0] CSR_R_MEASURE   = 3'd2;
   localparam logic [2:0] CSR_TIME_STEP   = 3'd3;
   localparam logic [2:0] CSR_START_ANGLE = 3'd4;

   localparam logic [30:0] RST_Q_ANGLE   = 31'd16777;
   localparam logic [30:0] RST_Q_BIAS    = 31'd50332;
   localparam logic [30:0] RST_R_MEASURE = 31'd503316;
   localparam logic [24:0] RST_TIME_STEP = 25'd167772;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_RATE,
      ST_M_DT_RATE,
      ST_ANGLE,
      ST_M_DT_P11,
      ST_T,
      ST_M_DT_T,
      ST_M_QB_DT,
      ST_PRED,
      ST_DIV0_START,
      ST_DIV0,
      ST_DIV1_START,
      ST_DIV1,
      ST_INNOV,
      ST_M_K0_Y,
      ST_M_K1_Y,
      ST_M_K0_P00,
      ST_M_K0_P01,
      ST_M_K1_P00,
      ST_M_K1_P01,
      ST_DONE
   } abkf_state_type;

   // divider control between sequencer and division unit
   typedef struct packed {
      logic        start;
      logic [63:0] dividend;
      logic [63:0] divisor;
   } abkf_div_req_type;

   typedef struct packed {
      logic        busy;
      logic        done;
      logic [63:0] quotient;
   } abkf_div_rsp_type;

   function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
      if (x > 66'sd2147483647) begin
         return 32'sh7FFFFFFF;
      end else if (x < -66'sd2147483648) begin
         return 32'sh80000000;
      end else begin
         return x[31:0];
      end
   endfunction

endpackage

// ===== hw/rtl/abkf_div.sv =====
// Iterative signed 64-bit divider, truncating toward zero, one bit per cycle.
// Depends on abkf_pkg.
module abkf_div
   import abkf_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  abkf_div_req_type req,
   output abkf_div_rsp_type rsp
);

   logic [63:0] quo_ff, quo_in;
   logic [64:0] rem_ff, rem_in;
   logic [63:0] den_ff, den_in;
   logic        neg_ff, neg_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [64:0] rem_sh;
   logic [64:0] rem_sub;

   // shift in the next dividend bit and try a subtract
   always_comb begin
      rem_sh  = {rem_ff[63:0], quo_ff[63]};
      rem_sub = rem_sh - {1'b0, den_ff};
   end

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         quo_in  = req.dividend[63] ? (64'd0 - req.dividend) : req.dividend;
         den_in  = req.divisor[63] ? (64'd0 - req.divisor) : req.divisor;
         neg_in  = req.dividend[63] ^ req.divisor[63];
         rem_in  = '0;
         cnt_in  = 7'(DivSteps);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!rem_sub[64]) begin
            rem_in = rem_sub;
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_comb begin
      rsp.busy     = busy_ff;
      rsp.done     = done_ff;
      rsp.quotient = neg_ff ? (64'd0 - quo_ff) : quo_ff;
   end

`ifndef SYNTHESIS
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp.done |-> $past(busy_ff)) else $error("divider done without busy");
   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      req.start |-> !busy_ff) else $error("divider restarted while busy");
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp.done |=> !rsp.done) else $error("divider done held");
`endif

endmodule

// ===== hw/rtl/angle_bias_kalman_filter_unit.sv =====
// Angle and gyro bias Kalman filter unit: top level with sequencer and shared multiplier.
// From request accept to rsp_valid the sequencer runs two gain divisions plus 18 steps,
// ten of them on the single shared multiplier; both divisions are skipped when the
// innovation variance is zero. A request is finished before the next one is taken;
// the next request is taken while the
// result waits in the output register, and a result still waiting stalls the finish step.
// Reset (synchronous, active high) restores the register defaults, zero angle,
// zero bias and zero covariance. Depends on abkf_pkg and abkf_div.
module angle_bias_kalman_filter_unit
   import abkf_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_measured_angle,
   input  logic signed [31:0] req_measured_rate,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_angle_estimate,
   output logic signed [31:0] rsp_unbiased_rate,
   input  logic               csr_write,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_data
);

   abkf_state_type state_ff, state_in;

   logic [30:0] q_angle_ff, q_bias_ff, r_measure_ff;
   logic [24:0] time_step_ff;
   logic signed [31:0] angle_ff, angle_in, bias_ff, bias_in;
   logic signed [31:0] p00_ff, p00_in, p01_ff, p01_in, p10_ff, p10_in, p11_ff, p11_in;
   logic signed [31:0] mang_ff, mang_in, mrate_ff, mrate_in;
   logic signed [31:0] rate_ff, rate_in, k0_ff, k0_in, k1_ff, k1_in, y_ff, y_in;
   logic signed [34:0] t_ff, t_in;
   logic signed [65:0] prod_ff, prod_in;
   logic signed [65:0] acc_ff, acc_in;
   logic signed [32:0] mul_a;
   logic signed [34:0] mul_b;
   logic signed [65:0] prod_q;
   logic signed [65:0] sval;
   logic               szero_ff, szero_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] p01_old_ff;
   abkf_div_req_type   div_req;
   abkf_div_rsp_type   div_rsp;

   abkf_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // shared multiplier operands
   always_comb begin
      case (state_ff)
         ST_M_DT_RATE: begin mul_a = {8'd0, time_step_ff}; mul_b = 35'(rate_ff); end
         ST_M_DT_P11:  begin mul_a = {8'd0, time_step_ff}; mul_b = 35'(p11_ff); end
         ST_M_DT_T:    begin mul_a = {8'd0, time_step_ff}; mul_b = t_ff; end
         ST_M_QB_DT:   begin mul_a = {2'd0, q_bias_ff}; mul_b = {10'd0, time_step_ff}; end
         ST_M_K0_Y:    begin mul_a = 33'(k0_ff); mul_b = 35'(y_ff); end
         ST_M_K1_Y:    begin mul_a = 33'(k1_ff); mul_b = 35'(y_ff); end
         ST_M_K0_P00:  begin mul_a = 33'(k0_ff); mul_b = 35'(p00_ff); end
         ST_M_K0_P01:  begin mul_a = 33'(k0_ff); mul_b = 35'(p01_ff); end
         ST_M_K1_P00:  begin mul_a = 33'(k1_ff); mul_b = 35'(p00_ff); end
         ST_M_K1_P01:  begin mul_a = 33'(k1_ff); mul_b = 35'(p01_old_ff); end
         default:      begin mul_a = '0; mul_b = '0; end
      endcase
      prod_q = (66'(mul_a) * 66'(mul_b)) >>> 24;
   end

   assign sval = 66'(p00_ff) + 66'($signed({1'b0, r_measure_ff}));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:       if (req_valid) state_in = ST_RATE;
         ST_RATE:       state_in = ST_M_DT_RATE;
         ST_M_DT_RATE:  state_in = ST_ANGLE;
         ST_ANGLE:      state_in = ST_M_DT_P11;
         ST_M_DT_P11:   state_in = ST_T;
         ST_T:          state_in = ST_M_DT_T;
         ST_M_DT_T:     state_in = ST_M_QB_DT;
         ST_M_QB_DT:    state_in = ST_PRED;
         ST_PRED:       state_in = ST_DIV0_START;
         ST_DIV0_START: state_in = ST_DIV0;
         ST_DIV0:       if (div_rsp.done || szero_ff) state_in = ST_DIV1_START;
         ST_DIV1_START: state_in = ST_DIV1;
         ST_DIV1:       if (div_rsp.done || szero_ff) state_in = ST_INNOV;
         ST_INNOV:      state_in = ST_M_K0_Y;
         ST_M_K0_Y:     state_in = ST_M_K1_Y;
         ST_M_K1_Y:     state_in = ST_M_K0_P00;
         ST_M_K0_P00:   state_in = ST_M_K0_P01;
         ST_M_K0_P01:   state_in = ST_M_K1_P00;
         ST_M_K1_P00:   state_in = ST_M_K1_P01;
         ST_M_K1_P01:   state_in = ST_DONE;
         ST_DONE:       if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         default:       state_in = ST_IDLE;
      endcase
   end

   // datapath updates per step
   always_comb begin
      angle_in = angle_ff; bias_in = bias_ff;
      p00_in = p00_ff; p01_in = p01_ff; p10_in = p10_ff; p11_in = p11_ff;
      mang_in = mang_ff; mrate_in = mrate_ff; rate_in = rate_ff;
      k0_in = k0_ff; k1_in = k1_ff; y_in = y_ff; t_in = t_ff;
      prod_in = prod_q; acc_in = acc_ff; szero_in = szero_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      div_req.start = 1'b0;
      div_req.dividend = 64'(p00_ff) <<< 24;
      div_req.divisor = sval[63:0];
      case (state_ff)
         ST_IDLE: begin
            mang_in = req_measured_angle; mrate_in = req_measured_rate;
         end
         ST_RATE: rate_in = sat32(66'(mrate_ff) - 66'(bias_ff));
         ST_ANGLE: angle_in = sat32(66'(angle_ff) + prod_ff);
         ST_T: begin
            // keep dt*P11 for the P01 and P10 prediction
            t_in = 35'(prod_ff - 66'(p01_ff) - 66'(p10_ff)
                       + 66'($signed({1'b0, q_angle_ff})));
            acc_in = prod_ff;
         end
         ST_M_QB_DT: p00_in = sat32(66'(p00_ff) + prod_ff);
         ST_PRED: begin
            p01_in = sat32(66'(p01_ff) - acc_ff);
            p10_in = sat32(66'(p10_ff) - acc_ff);
            p11_in = sat32(66'(p11_ff) + prod_ff);
         end
         ST_DIV0_START: begin
            szero_in = (sval == '0);
            div_req.start = (sval != '0);
         end
         ST_DIV0: if (div_rsp.done || szero_ff)
            k0_in = szero_ff ? '0 : sat32(66'($signed(div_rsp.quotient)));
         ST_DIV1_START: begin
            div_req.dividend = 64'(p10_ff) <<< 24;
            div_req.start = !szero_ff;
         end
         ST_DIV1: if (div_rsp.done || szero_ff)
            k1_in = szero_ff ? '0 : sat32(66'($signed(div_rsp.quotient)));
         ST_INNOV: y_in = sat32(66'(mang_ff) - 66'(angle_ff));
         ST_M_K0_Y: angle_in = sat32(66'(angle_ff) + prod_q);
         ST_M_K1_Y: bias_in = sat32(66'(bias_ff) + prod_q);
         ST_M_K0_P00: acc_in = prod_q;
         ST_M_K0_P01: p01_in = sat32(66'(p01_ff) - prod_q);
         ST_M_K1_P00: begin
            p10_in = sat32(66'(p10_ff) - prod_q);
            p00_in = sat32(66'(p00_ff) - acc_ff);
         end
         // K1*P01 uses P01 as held before the update
         ST_M_K1_P01: p11_in = sat32(66'(p11_ff) - prod_q);
         ST_DONE: if (!rsp_valid_ff || rsp_ready) rsp_valid_in = 1'b1;
         default: ;
      endcase
      // load the start angle on a register write
      if (csr_write && csr_index == CSR_START_ANGLE) angle_in = csr_data;
   end

   // hold P01 from before its update for the K1*P01 step
   always_ff @(posedge clock) begin
      if (state_ff == ST_M_K0_P00) p01_old_ff <= p01_ff;
   end

   // registers and configuration
   always_ff @(posedge clock) begin
      mang_ff <= mang_in; mrate_ff <= mrate_in; rate_ff <= rate_in;
      k0_ff <= k0_in; k1_ff <= k1_in; y_ff <= y_in; t_ff <= t_in;
      prod_ff <= prod_in; acc_ff <= acc_in; szero_ff <= szero_in;
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         q_angle_ff <= RST_Q_ANGLE; q_bias_ff <= RST_Q_BIAS;
         r_measure_ff <= RST_R_MEASURE; time_step_ff <= RST_TIME_STEP;
         angle_ff <= '0; bias_ff <= '0;
         p00_ff <= '0; p01_ff <= '0; p10_ff <= '0; p11_ff <= '0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         angle_ff <= angle_in; bias_ff <= bias_in;
         p00_ff <= p00_in; p01_ff <= p01_in; p10_ff <= p10_in;
         p11_ff <= p11_in;
         if (csr_write) begin
            case (csr_index)
               CSR_Q_ANGLE:     q_angle_ff <= csr_data[30:0];
               CSR_Q_BIAS:      q_bias_ff <= csr_data[30:0];
               CSR_R_MEASURE:   r_measure_ff <= csr_data[30:0];
               CSR_TIME_STEP:   time_step_ff <= csr_data[24:0];
               default: ;
            endcase
         end
      end
   end

   // hold the result until taken
   logic signed [31:0] out_angle_ff, out_rate_ff;
   always_ff @(posedge clock) begin
      if (state_ff == ST_DONE && (!rsp_valid_ff || rsp_ready)) begin
         out_angle_ff <= angle_ff;
         out_rate_ff  <= rate_ff;
      end
   end

   assign req_ready          = (state_ff == ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_angle_estimate = out_angle_ff;
   assign rsp_unbiased_rate  = out_rate_ff;

`ifndef SYNTHESIS
   a_div_idle_start: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> (state_ff == ST_DIV0_START || state_ff == ST_DIV1_START))
      else $error("divider started outside gain steps");
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> state_ff == ST_RATE)
      else $error("accepted request not started");
   a_done_raises_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && state_in == ST_IDLE) |=> rsp_valid)
      else $error("finished request produced no response");
`endif

endmodule
